### hw/rtl/knl_pkg.sv
package knl_pkg;

    localparam int INDEX_W    = 16;
    localparam int DIST_W     = 32;
    localparam int CMD_W      = 2;
    localparam int KEEP_W     = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_POINTS = 65536;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);
    localparam logic              SKIP_RESET = 1'b1;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_SELF  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_OFFER  = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] point_index;
        logic [DIST_W-1:0]  candidate_distance;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] vertex_index;
        logic               is_last;
        logic [DIST_W-1:0]  radius;
    } t_out_word;

    // broadcast to every cell
    typedef struct packed {
        logic               insert;
        logic [DIST_W-1:0]  dst;
        logic [INDEX_W-1:0] idx;
    } t_cell_ctl;

    // handed from one cell to the next
    typedef struct packed {
        logic               lt;
        logic [DIST_W-1:0]  dst;
        logic [INDEX_W-1:0] idx;
    } t_cell_link;

endpackage

### hw/rtl/k_nearest_insertion_list.sv
// k-nearest selector, one query at a time.
// Input channel (i_in_valid / o_in_stall, i_in_word): start records the query
// index and empties the list; offer inserts a candidate, and candidates are taken
// back to back; finish emits the edge.
// Output channel (o_out_valid / i_out_stall, o_out_word): per finish, the query
// index, then min(kept, keep) neighbour indices nearest first, is_last on the
// final word, the same radius on every word.
// After finish is taken, S_RAD registers the radius, then S_EMIT loads the first
// word into the output register; then one word per cycle while not stalled. Input
// is stalled from finish until the last word is in the output register. A stalled
// output word holds; emission simply waits.
// Storage is a chain of MAX_NEIGHBORS + 1 cells; an insert compares in every
// cell at once and shifts the farther entries one cell along.
// Reset (synchronous, active low): keep_count 8, skip_self 1, query 0, list empty; no
// output word pending. The user does configuration via i_cfg_we only when idle, unchecked.
module k_nearest_insertion_list
    import knl_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word
);

    localparam int CAP_MAX = MAX_NEIGHBORS + 1;
    localparam int CW      = $clog2(CAP_MAX + 1);  // holds a count up to CAP_MAX
    localparam int AW      = $clog2(CAP_MAX);      // cell address / emit position

    // control state
    t_state              r_state, n_state;
    logic [KEEP_W-1:0]   r_keep, n_keep;
    logic                r_skip, n_skip;
    logic [INDEX_W-1:0]  r_query, n_query;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_emit, n_emit;
    logic                r_out_valid, n_out_valid;
    // payload
    logic [DIST_W:0]     r_sum, n_sum;
    logic [DIST_W-1:0]   r_radius, n_radius;
    t_out_word           r_out_word, n_out_word;

    t_cell_ctl           cell_ctl;
    t_cell_link          links [CAP_MAX];
    logic [CAP_MAX-1:0]  cell_valid;

    logic [CW-1:0]       keep_eff;
    logic [CW-1:0]       cap;
    logic [CW-1:0]       eff_cnt;
    logic                full;
    logic                tail_lt;
    logic [DIST_W-1:0]   dist_a;
    logic [DIST_W-1:0]   dist_b;
    logic [DIST_W:0]     rad_inc;
    logic                in_acc;
    logic                out_take;
    logic                offer_ok;
    logic [AW-1:0]       rd_addr;

    // ---- the cell chain ----
    genvar g;
    generate
        for (g = 0; g < CAP_MAX; g++) begin : g_cell
            assign cell_valid[g] = (CW'(g) < eff_cnt);
            if (g == 0) begin : g_head
                // the head sees "all nearer" on its left: it takes the candidate
                knl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (cell_ctl),
                    .i_valid (cell_valid[g]),
                    .i_left  (t_cell_link'{lt: 1'b1, dst: '0, idx: '0}),
                    .o_link  (links[g])
                );
            end else begin : g_body
                knl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (cell_ctl),
                    .i_valid (cell_valid[g]),
                    .i_left  (links[g-1]),
                    .o_link  (links[g])
                );
            end
        end
    endgenerate

    // ---- capacity: keep clamped to 1..MAX_NEIGHBORS, one spare for the radius ----
    always_comb begin
        if (r_keep == '0) begin
            keep_eff = CW'(1);
        end else if (int'(r_keep) > MAX_NEIGHBORS) begin
            keep_eff = CW'(MAX_NEIGHBORS);
        end else begin
            keep_eff = CW'(r_keep);
        end
    end

    assign cap     = keep_eff + CW'(1);
    assign eff_cnt = (r_count > cap) ? cap : r_count;   // drops entries past a lowered keep
    assign full    = (eff_cnt == cap);

    // largest kept entry vs candidate, and the two largest distances
    always_comb begin
        tail_lt = 1'b0;
        dist_a  = '0;
        dist_b  = '0;
        for (int i = 0; i < CAP_MAX; i++) begin
            if (i + 1 == int'(cap) && links[i].lt) begin
                tail_lt = 1'b1;
            end
            if (i + 1 == int'(eff_cnt)) begin
                dist_a = dist_a | links[i].dst;
            end
            if (i + 2 == int'(eff_cnt)) begin
                dist_b = dist_b | links[i].dst;
            end
        end
    end

    assign offer_ok = !(r_skip && (i_in_word.point_index == r_query))
                      && !(int'(i_in_word.point_index) >= MAX_POINTS)
                      && !(full && tail_lt);

    // floor(sum / 2) + 1, saturating
    assign rad_inc = {1'b0, r_sum[DIST_W:1]} + (DIST_W+1)'(1);

    assign rd_addr    = r_pos - AW'(1);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_keep      = r_keep;
        n_skip      = r_skip;
        n_query     = r_query;
        n_count     = r_count;
        n_pos       = r_pos;
        n_emit      = r_emit;
        n_sum       = r_sum;
        n_radius    = r_radius;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;

        cell_ctl.insert = 1'b0;
        cell_ctl.dst    = i_in_word.candidate_distance;
        cell_ctl.idx    = i_in_word.point_index;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEEP_COUNT: n_keep = i_cfg_data[KEEP_W-1:0];
                REG_SKIP_SELF:  n_skip = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.command)
                        CMD_START: begin
                            n_query = i_in_word.point_index;
                            n_count = '0;
                        end
                        CMD_OFFER: begin
                            n_count = eff_cnt;
                            if (offer_ok) begin
                                cell_ctl.insert = 1'b1;
                                n_count = full ? cap : eff_cnt + CW'(1);
                            end
                        end
                        CMD_FINISH: begin
                            n_count = eff_cnt;
                            n_emit  = AW'((eff_cnt < keep_eff) ? eff_cnt : keep_eff);
                            n_pos   = '0;
                            // one kept: count its distance twice so the halving undoes it
                            n_sum   = {1'b0, dist_a}
                                      + {1'b0, (eff_cnt == CW'(1)) ? dist_a : dist_b};
                            n_state = S_RAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RAD: begin
                n_radius = rad_inc[DIST_W] ? '1 : rad_inc[DIST_W-1:0];
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (out_take) begin
                    n_out_valid             = 1'b1;
                    n_out_word.radius       = r_radius;
                    n_out_word.is_last      = (r_pos == r_emit);
                    n_out_word.vertex_index = (r_pos == '0) ? r_query : links[rd_addr].idx;
                    if (r_pos == r_emit) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_keep      <= KEEP_RESET;
            r_skip      <= SKIP_RESET;
            r_query     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keep      <= n_keep;
            r_skip      <= n_skip;
            r_query     <= n_query;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_radius   <= n_radius;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### hw/rtl/knl_cell.sv
module knl_cell
    import knl_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_valid,
    input  t_cell_link i_left,
    output t_cell_link o_link
);

    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  n_dist;
    logic [INDEX_W-1:0] r_idx;
    logic [INDEX_W-1:0] n_idx;
    logic               lt;

    // entry stays put when it is nearer than the candidate
    assign lt = i_valid && (r_dist < i_ctl.dst);

    always_comb begin
        n_dist = r_dist;
        n_idx  = r_idx;
        if (i_ctl.insert && !lt) begin
            if (i_left.lt) begin
                n_dist = i_ctl.dst;
                n_idx  = i_ctl.idx;
            end else begin
                n_dist = i_left.dst;
                n_idx  = i_left.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_idx  <= n_idx;
    end

    assign o_link = '{lt: lt, dst: r_dist, idx: r_idx};

endmodule

### verif/k_nearest_insertion_list_tb.sv
`timescale 1ns / 100ps

module k_nearest_insertion_list_tb
    import knl_pkg::*;
;

    localparam int NB_MAX        = 16;
    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEM_TARGET   = 470;
    localparam int REPORT_CAP    = 40;
    localparam int GAP_MAX       = 14;

    // command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_KEEP_COUNT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;

    k_nearest_insertion_list #(
        .MAX_NEIGHBORS(NB_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the neighbour list: registers, current query, sorted list
    // of keep+1 entries (the extra one only feeds the radius).
    // ------------------------------------------------------------------
    logic [KEEP_W-1:0]  keep_reg;
    logic               skip_reg;
    logic [INDEX_W-1:0] cur_query;
    int unsigned        list_len;
    logic [DIST_W-1:0]  near_dist [NB_MAX+1];
    logic [INDEX_W-1:0] near_idx  [NB_MAX+1];

    // output words still owed by the block, oldest first
    t_out_word edge_due [$];

    int unsigned errors     = 0;
    int unsigned words_sent = 0;
    int unsigned cycles     = 0;

    // sender/receiver idling on or off; hold-off requests for the receiver
    logic        idle_on   = 1'b1;
    int unsigned hold_reqs = 0;

    // keep_count of 0 behaves as 1, anything above the list size as the size
    function automatic int unsigned keep_limit();
        int unsigned k;
        k = 32'(keep_reg);
        if (k < 1) k = 1;
        if (k > NB_MAX) k = NB_MAX;
        return k;
    endfunction

    function automatic void insert_candidate(logic [INDEX_W-1:0] idx,
                                             logic [DIST_W-1:0] dst);
        int unsigned cap;
        int unsigned pos;
        int unsigned i;
        cap = keep_limit() + 1;
        pos = 0;
        // a lowered keep trims the list lazily
        if (list_len > cap) list_len = cap;
        if (skip_reg && idx == cur_query) return;
        // full and farther than the worst kept entry: rejected
        if (list_len == cap && dst > near_dist[cap-1]) return;
        // equal distances: newcomer goes ahead
        while (pos < list_len && near_dist[pos] < dst) pos++;
        if (list_len < cap) list_len++;
        for (i = list_len - 1; i > pos; i--) begin
            near_dist[i] = near_dist[i-1];
            near_idx[i]  = near_idx[i-1];
        end
        near_dist[pos] = dst;
        near_idx[pos]  = idx;
    endfunction

    function automatic void emit_edge();
        int unsigned       keep;
        int unsigned       emit;
        int unsigned       i;
        logic [DIST_W:0]   sum;
        logic [DIST_W-1:0] rad;
        t_out_word         w;
        keep = keep_limit();
        if (list_len > keep + 1) list_len = keep + 1;
        // floored midpoint of the two largest, or the single one, or zero;
        // then one LSB on top, saturating
        if (list_len >= 2)
            sum = ({1'b0, near_dist[list_len-1]} + {1'b0, near_dist[list_len-2]}) >> 1;
        else if (list_len == 1)
            sum = {1'b0, near_dist[0]};
        else
            sum = '0;
        sum  = sum + 1'b1;
        rad  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        emit = list_len < keep ? list_len : keep;
        w.vertex_index = cur_query;
        w.is_last      = (emit == 0);
        w.radius       = rad;
        edge_due.push_back(w);
        for (i = 0; i < emit; i++) begin
            w.vertex_index = near_idx[i];
            w.is_last      = (i + 1 == emit);
            edge_due.push_back(w);
        end
    endfunction

    function automatic void track_word(t_in_word w);
        case (w.command)
            CMD_START: begin
                cur_query = w.point_index;
                list_len  = 0;
            end
            CMD_OFFER:  insert_candidate(w.point_index, w.candidate_distance);
            CMD_FINISH: emit_edge();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: compare each taken word with the oldest owed one, then draw
    // the stall for the next word. A hold-off request overrides all.
    // ------------------------------------------------------------------
    function automatic void report_mismatch(string field, logic [DIST_W-1:0] want,
                                            logic [DIST_W-1:0] got);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function automatic void check_word(t_out_word got);
        t_out_word want;
        if (edge_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: output word %h with nothing expected", $time, got);
            return;
        end
        want = edge_due.pop_front();
        if (got.vertex_index !== want.vertex_index)
            report_mismatch("vertex_index", DIST_W'(want.vertex_index),
                            DIST_W'(got.vertex_index));
        if (got.is_last !== want.is_last)
            report_mismatch("is_last", DIST_W'(want.is_last), DIST_W'(got.is_last));
        if (got.radius !== want.radius)
            report_mismatch("radius", want.radius, got.radius);
    endfunction

    int unsigned rx_wait   = 0;
    int unsigned rx_hold   = 0;
    int unsigned hold_done = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            check_word(o_out_word);
            rx_wait = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        end
        if (hold_reqs != hold_done) begin
            hold_done = hold_reqs;
            rx_hold   = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic t_in_word make_word(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                           logic [DIST_W-1:0] dst);
        t_in_word w;
        w.command            = cmd;
        w.point_index        = idx;
        w.candidate_distance = dst;
        return w;
    endfunction

    // Offers one word and holds it until taken; valid is only dropped when a
    // gap is drawn, so back-to-back words never toggle it within a step.
    task automatic send_word(t_in_word w);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        track_word(w);
        words_sent++;
    endtask

    task automatic start_query(logic [INDEX_W-1:0] q);
        send_word(make_word(CMD_START, q, $urandom));
    endtask

    task automatic offer(logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] dst);
        send_word(make_word(CMD_OFFER, idx, dst));
    endtask

    task automatic finish_query();
        send_word(make_word(CMD_FINISH, INDEX_W'($urandom_range(0, 16'hFFFF)), $urandom));
    endtask

    // sender pauses until every owed word is back and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (edge_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while idle; ends with i_cfg_we low at an edge so back-to-back writes stay clean
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == REG_KEEP_COUNT)
            keep_reg = data[KEEP_W-1:0];
        else
            skip_reg = data[0];
        @(posedge i_clk);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 7);   // plenty of ties
            1:       return DIST_MAX - $urandom_range(0, 3);
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return cur_query;              // self candidate
            1:       return INDEX_W'($urandom_range(0, 3));
            default: return INDEX_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_keep();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(NB_MAX);
            3:       return '1;
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset settings: finish and offers with no start use query 0
    task automatic test_before_start();
        finish_query();                 // empty list, radius one LSB
        offer(16'd0, 32'd9);            // same as reset query, skipped
        offer(16'd3, 32'd40);
        finish_query();
        finish_query();                 // repeated finish gives the same edge
        send_word(make_word(CMD_UNUSED, '1, '1));
        wait_idle();
    endtask

    task automatic test_extremes();
        write_reg(REG_SKIP_SELF, 5'b11110);     // skip off, upper bits ignored
        write_reg(REG_KEEP_COUNT, 5'd2);
        start_query(16'hFFFF);
        offer(16'hFFFF, DIST_MAX);      // self, kept as skip is off
        offer(16'h0000, DIST_MAX);      // tie goes ahead
        offer(16'h1234, '0);
        offer(16'h4321, '0);            // list full, farthest dropped
        offer(16'h5555, DIST_MAX);      // equals largest on a full list
        offer(16'h6666, DIST_MAX - 1);
        finish_query();
        start_query(16'h0001);
        offer(16'h0002, DIST_MAX);
        finish_query();                 // single entry, saturating radius
        offer(16'h0003, DIST_MAX);
        finish_query();                 // two maximum distances, saturating
        wait_idle();
    endtask

    // extremes of keep_count with both skip settings
    task automatic test_keep_sweep();
        logic [CFG_W-1:0] keeps [5];
        int unsigned      n;
        keeps = '{5'd1, 5'd16, 5'd17, 5'd31, 5'd0};
        foreach (keeps[k]) begin
            for (int s = 0; s < 2; s++) begin
                write_reg(REG_KEEP_COUNT, keeps[k]);
                write_reg(REG_SKIP_SELF, {(CFG_W-1)'($urandom_range(0, 15)), 1'(s)});
                idle_on = $urandom_range(0, 2) != 0;
                start_query(INDEX_W'($urandom_range(0, 3)));
                n = $urandom_range(0, keep_limit() + 4);
                repeat (n) offer(pick_index(), pick_distance());
                finish_query();
                wait_idle();
            end
        end
        idle_on = 1'b1;
    endtask

    // keep lowered mid-query: trimming happens on the next offer or finish
    task automatic test_keep_lowered();
        write_reg(REG_KEEP_COUNT, 5'd16);
        write_reg(REG_SKIP_SELF, 5'd1);
        start_query(16'h0042);
        repeat (14) offer(pick_index(), pick_distance());
        wait_idle();
        write_reg(REG_KEEP_COUNT, 5'd3);
        finish_query();
        wait_idle();
        write_reg(REG_KEEP_COUNT, 5'd16);
        finish_query();                 // stays trimmed after raising keep
        wait_idle();
        write_reg(REG_KEEP_COUNT, 5'd2);
        offer(pick_index(), pick_distance());
        finish_query();
        wait_idle();
    endtask

    // receiver holds off for a long stretch while words keep coming, so the
    // output fills and the input stalls behind a pending finish
    task automatic test_output_hold();
        write_reg(REG_KEEP_COUNT, 5'd16);
        idle_on   = 1'b0;
        hold_reqs <= hold_reqs + 1;
        @(posedge i_clk);
        start_query(INDEX_W'($urandom_range(0, 16'hFFFF)));
        repeat (20) offer(pick_index(), pick_distance());
        finish_query();
        repeat (5) offer(pick_index(), pick_distance());
        finish_query();
        finish_query();
        wait_idle();
        idle_on = 1'b1;
    endtask

    // mostly well-formed queries with random content, some noise in between
    task automatic test_random();
        int unsigned n;
        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_reg(REG_KEEP_COUNT, pick_keep());
                write_reg(REG_SKIP_SELF, CFG_W'($urandom_range(0, 31)));
            end
            idle_on = $urandom_range(0, 3) != 0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
            // now and then no start: the old list carries on
            if ($urandom_range(0, 7) != 0)
                start_query(INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 16'hFFFF)));
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: send_word(make_word(CMD_UNUSED, INDEX_W'($urandom_range(0, 16'hFFFF)),
                                           $urandom));
                    1: finish_query();
                    default: ;
                endcase
                offer(pick_index(), pick_distance());
            end
            finish_query();
            if ($urandom_range(0, 5) == 0) finish_query();
            if ($urandom_range(0, 7) == 0) wait_idle();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        keep_reg  = KEEP_RESET;
        skip_reg  = SKIP_RESET;
        cur_query = '0;
        list_len  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_start();
        test_extremes();
        test_keep_sweep();
        test_keep_lowered();
        test_output_hold();
        test_random();

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("k_nearest_insertion_list_tb passed");
        end else begin
            $display("k_nearest_insertion_list_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("k_nearest_insertion_list_tb failed");
        $finish;
    end

endmodule

### k_nearest_insertion_list.f
hw/rtl/knl_pkg.sv
hw/rtl/knl_cell.sv
hw/rtl/k_nearest_insertion_list.sv
verif/k_nearest_insertion_list_tb.sv
